FILE: design/gkt_pkg.sv
// Shared types and constants of the grouped K-th hit trigger.
// Depends on nothing; every other design file imports it.
package gkt_pkg;

    localparam int CH_W      = 6;
    localparam int CHANNELS  = 64;
    localparam int TIME_W    = 24;
    localparam int CNT_W     = 4;
    localparam int THR_W     = 4;
    localparam int FIRST_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int GCNT_W    = 6;
    localparam int GRP_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_AW    = 2;

    localparam logic [CNT_W-1:0] COUNT_SAT = 4'd15;

    localparam logic [CFG_AW-1:0] REG_THRESHOLD_K  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FIRST_CHANNEL = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GROUP_SIZE   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_GROUP_COUNT  = 2'd3;

    typedef struct packed {
        logic [FIRST_W-1:0] first_channel;
        logic [SIZE_W-1:0]  group_size;
        logic [GCNT_W-1:0]  group_count;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [GRP_W-1:0] grp;
    } t_map_ent;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_mem_ctl;

endpackage

FILE: design/gkt_chmap.sv
// Channel-to-group map: a memory rebuilt by a sweep over all channels.
// Depends on gkt_pkg.
module gkt_chmap #(
    parameter int MAX_GROUPS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  gkt_pkg::t_cfg            i_cfg,
    input  logic                     i_rd_en,
    input  logic [gkt_pkg::CH_W-1:0] i_rd_ch,
    output gkt_pkg::t_map_ent        o_ent,
    output logic                     o_busy
);
    import gkt_pkg::*;

    localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [GRP_W:0]   GMAX    = (GRP_W + 1)'(MAX_GROUPS);

    t_map_ent        r_mem [CHANNELS];
    t_map_ent        r_rd_ent;
    logic            r_busy;
    logic [CH_W-1:0] r_sw_ch;
    logic [GRP_W:0]  r_sw_grp;
    logic [SIZE_W-1:0] r_sw_off;

    logic [GRP_W:0]  w_geff;
    logic            w_step;
    t_map_ent        w_ent;

    always_comb begin
        w_geff = ({1'b0, i_cfg.group_count} > GMAX) ? GMAX : {1'b0, i_cfg.group_count};
        w_step = (r_sw_ch >= i_cfg.first_channel) && (i_cfg.group_size != '0);
        w_ent.hit = w_step && (r_sw_grp < w_geff);
        w_ent.grp = r_sw_grp[GRP_W-1:0];
    end

    // The sweep walks the channels in order, so the group index is a running
    // count instead of a division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_busy   <= 1'b1;
            r_sw_ch  <= '0;
            r_sw_grp <= '0;
            r_sw_off <= '0;
        end else if (r_busy) begin
            r_sw_ch <= r_sw_ch + CH_W'(1);
            if (r_sw_ch == CH_LAST) begin
                r_busy <= 1'b0;
            end
            if (w_step) begin
                if (r_sw_off + SIZE_W'(1) == i_cfg.group_size) begin
                    r_sw_off <= '0;
                    r_sw_grp <= r_sw_grp + (GRP_W + 1)'(1);
                end else begin
                    r_sw_off <= r_sw_off + SIZE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_sw_ch] <= w_ent;
        end
        if (i_rd_en) begin
            r_rd_ent <= r_mem[i_rd_ch];
        end
    end

    assign o_ent  = r_rd_ent;
    assign o_busy = r_busy;

`ifndef SYNTH
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ($past(r_sw_ch) == CH_LAST) && !$past(i_restart))
        else $error("channel map sweep ended early");
`endif

endmodule

FILE: design/gkt_grpmem.sv
// Group row memory: one row per group holding its count and sorted times,
// with a valid bit per row so that a whole event can be cleared at once.
// Depends on gkt_pkg.
module gkt_grpmem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 196
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gkt_pkg::t_mem_ctl                     i_ctl,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    output logic [WIDTH-1:0]                      o_rd_data,
    output logic                                  o_rd_vld
);
    import gkt_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [DEPTH-1:0] r_gvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_gvld[i_rd_addr];
        end
    end

    // A row that is not valid reads as an empty group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_gvld <= '0;
        end else if (i_ctl.wr) begin
            r_gvld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

`ifndef SYNTH
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |=> (r_gvld == '0))
        else $error("group rows not cleared");
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr && !i_ctl.clr) |=> r_gvld[$past(i_wr_addr)])
        else $error("written row not marked valid");
`endif

endmodule

FILE: design/grouped_kth_hit_trigger.sv
// Grouped K-th hit trigger. Requests carry photon hits of one event (channel,
// arrival time) and the last request of the event is marked. Channels from
// first_channel on are split into group_count groups of group_size channels;
// other hits are dropped. Each group keeps its K_MAX earliest times sorted plus
// a hit count saturating at 15. On the last request the block reports the
// earliest threshold_k-th time over all groups holding at least threshold_k
// hits (trigger_valid low and time zero when none does) and empties all groups.
// Steps: a request without an in-range hit takes the channel map read; one
// with a hit adds a group row read, then the sorted insert and write back to
// the row memory. The event end then adds a scan of all MAX_GROUPS rows, one
// row read per cycle, a drain step for the last read and a step to load the
// result register; a result waiting there stalls only the next event end.
// After reset and after every configuration write the channel map is rebuilt
// by a sweep over all channels during which no request is accepted.
// Depends on gkt_pkg, gkt_chmap and gkt_grpmem.
module grouped_kth_hit_trigger #(
    parameter int MAX_GROUPS = 32,
    parameter int K_MAX      = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gkt_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [gkt_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_hit_present,
    input  logic [gkt_pkg::CH_W-1:0]   i_channel,
    input  logic [gkt_pkg::TIME_W-1:0] i_hit_time,
    input  logic                       i_last_in_event,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [gkt_pkg::TIME_W-1:0] o_trigger_time,
    output logic                       o_trigger_valid
);
    import gkt_pkg::*;

    localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int KW     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int WORD_W = CNT_W + K_MAX * TIME_W;
    localparam logic [GW-1:0]    G_LAST = GW'(MAX_GROUPS - 1);
    localparam logic [THR_W:0]   K_LIM  = (THR_W + 1)'(K_MAX);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_MODIFY = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_HOLD   = 7'b1000000
    } t_state;

    // Configuration registers.
    logic [THR_W-1:0] r_thr;
    t_cfg             r_cfg;

    // Control and the request being worked on.
    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_time;
    logic              r_present;
    logic              r_last;
    logic [GW-1:0]     r_grp;
    logic [GW-1:0]     r_scan_idx;
    logic              r_eval;
    logic              r_best_vld;
    logic [TIME_W-1:0] r_best;

    // Result register.
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_tv;

    // Submodule connections.
    logic              w_accept;
    logic              w_map_busy;
    t_map_ent          w_ent;
    t_mem_ctl          w_ctl;
    logic [GW-1:0]     w_rd_addr;
    logic [WORD_W-1:0] w_rd_word;
    logic              w_rd_vld;
    logic [WORD_W-1:0] w_wr_word;

    // Row decode and insert.
    logic [TIME_W-1:0] w_old [K_MAX];
    logic [K_MAX-1:0]  w_le;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_cnt_new;
    logic [THR_W-1:0]  w_k;
    logic              w_k_ok;
    logic [KW-1:0]     w_k_idx;
    logic [TIME_W-1:0] w_kth;
    logic              w_emit_go;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit_go  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr                <= THR_W'(4);
            r_cfg.first_channel  <= '0;
            r_cfg.group_size     <= SIZE_W'(4);
            r_cfg.group_count    <= GCNT_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD_K: begin
                    r_thr <= i_cfg_data[THR_W-1:0];
                end
                REG_FIRST_CHANNEL: begin
                    r_cfg.first_channel <= i_cfg_data[FIRST_W-1:0];
                end
                REG_GROUP_SIZE: begin
                    r_cfg.group_size <= i_cfg_data[SIZE_W-1:0];
                end
                REG_GROUP_COUNT: begin
                    r_cfg.group_count <= i_cfg_data[GCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Any configuration write rebuilds the channel map.
    gkt_chmap #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_chmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_cfg     (r_cfg),
        .i_rd_en   (w_accept),
        .i_rd_ch   (i_channel),
        .o_ent     (w_ent),
        .o_busy    (w_map_busy)
    );

    gkt_grpmem #(
        .DEPTH (MAX_GROUPS),
        .WIDTH (WORD_W)
    ) u_grpmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_grp),
        .i_wr_data (w_wr_word),
        .o_rd_data (w_rd_word),
        .o_rd_vld  (w_rd_vld)
    );

    // Threshold zero acts as one; a threshold above K_MAX never fires.
    always_comb begin
        w_k     = (r_thr == '0) ? THR_W'(1) : r_thr;
        w_k_ok  = {1'b0, w_k} <= K_LIM;
        w_k_idx = KW'(w_k - THR_W'(1));
    end

    // Sorted insert. The stored times below the count form a sorted prefix, so
    // the entries not above the new time form a prefix mask. The new time lands
    // right after that prefix and later entries move up by one; a full row
    // drops its last entry, and a time not below the last leaves it unchanged.
    always_comb begin
        w_cnt     = w_rd_vld ? w_rd_word[K_MAX*TIME_W +: CNT_W] : '0;
        w_cnt_new = (w_cnt == COUNT_SAT) ? w_cnt : w_cnt + CNT_W'(1);
        for (int j = 0; j < K_MAX; j++) begin
            w_old[j] = w_rd_word[j*TIME_W +: TIME_W];
            w_le[j]  = (int'(w_cnt) > j) && (w_old[j] <= r_time);
        end
        w_wr_word = '0;
        w_wr_word[K_MAX*TIME_W +: CNT_W] = w_cnt_new;
        for (int j = 0; j < K_MAX; j++) begin
            if (w_le[j]) begin
                w_wr_word[j*TIME_W +: TIME_W] = w_old[j];
            end else if (j == 0) begin
                w_wr_word[j*TIME_W +: TIME_W] = r_time;
            end else if (w_le[(j > 0) ? j - 1 : 0]) begin
                w_wr_word[j*TIME_W +: TIME_W] = r_time;
            end else begin
                w_wr_word[j*TIME_W +: TIME_W] = w_old[(j > 0) ? j - 1 : 0];
            end
        end
        w_kth = w_old[w_k_idx];
    end

    always_comb begin
        n_state   = r_state;
        w_ctl     = '0;
        w_rd_addr = r_scan_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_present && w_ent.hit) begin
                    w_ctl.rd  = 1'b1;
                    w_rd_addr = GW'(w_ent.grp);
                    n_state   = S_MODIFY;
                end else if (r_last) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MODIFY: begin
                w_ctl.wr = 1'b1;
                n_state  = r_last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                w_ctl.rd = 1'b1;
                if (r_scan_idx == G_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit_go) begin
                    w_ctl.clr = 1'b1;
                    n_state   = S_HOLD;
                end
            end
            S_HOLD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_idx <= '0;
            r_eval     <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_scan_idx <= r_scan_idx + GW'(1);
            end else begin
                r_scan_idx <= '0;
            end
            // Read data of the previous scan cycle is judged here.
            if (r_eval && w_k_ok && (w_cnt >= w_k)) begin
                if (!r_best_vld || (w_kth < r_best)) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (w_emit_go) begin
                r_best_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time    <= i_hit_time;
            r_present <= i_hit_present;
            r_last    <= i_last_in_event;
        end
        if (r_state == S_LOOK) begin
            r_grp <= GW'(w_ent.grp);
        end
        if (r_eval && w_k_ok && (w_cnt >= w_k) && (!r_best_vld || (w_kth < r_best))) begin
            r_best <= w_kth;
        end
    end

    // Result register: the next event end waits only while it is still full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_out_time <= r_best_vld ? r_best : '0;
            r_out_tv   <= r_best_vld;
        end
    end

    // The hold state after the clear keeps the next request from reading rows
    // while the valid bits settle.
    assign o_in_ready      = (r_state == S_IDLE) && !w_map_busy;
    assign o_out_valid     = r_out_valid;
    assign o_trigger_time  = r_out_time;
    assign o_trigger_valid = r_out_tv;

`ifndef SYNTH
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside the emit step");
    a_scan_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_SCAN) || (r_state == S_DRAIN))
        else $error("group scan left early");
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted request not looked up");
`endif

endmodule
